/* rtl/whp_pkg.sv */
// whp_pkg: shared types and constants of the wav header parser
// no dependencies; used by the step logic, the top level and the bench
`timescale 1ns / 1ps

package whp_pkg;

  // parse phase
  typedef enum logic [1:0] {
    PH_RIFF = 2'd0,
    PH_HDR  = 2'd1,
    PH_FMT  = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_WAVE   = 3'd1,
    ST_FMT_SHORT  = 3'd2,
    ST_NOT_PCM    = 3'd3,
    ST_NO_FMT     = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_e;

  // four-character tags, first byte in the top lane
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] PCM_TAG      = 16'd1;

  // byte positions inside each phase
  localparam logic [3:0] POS_RIFF_TAG_LAST = 4'd3;
  localparam logic [3:0] POS_RIFF_LAST     = 4'd11;
  localparam logic [3:0] POS_HDR_TAG_END   = 4'd4;
  localparam logic [3:0] POS_HDR_LAST      = 4'd7;
  localparam logic [3:0] POS_FMT_TAG_END   = 4'd2;
  localparam logic [3:0] POS_FMT_CH_HI     = 4'd3;
  localparam logic [3:0] POS_FMT_RATE_LO   = 4'd4;
  localparam logic [3:0] POS_FMT_RATE_END  = 4'd8;
  localparam logic [3:0] POS_FMT_BITS_LO   = 4'd14;
  localparam logic [3:0] POS_FMT_LAST      = 4'd15;

  // parser state
  typedef struct packed {
    phase_e      phase;
    logic [3:0]  byte_position;
    logic [31:0] tag_shift;
    logic [31:0] chunk_length;
    logic [31:0] skip_remaining;
    logic        pad_pending;
    logic        format_seen;
    logic [15:0] channels_held;
    logic [31:0] rate_held;
    logic [15:0] bits_held;
    logic        finished;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:          PH_RIFF,
    byte_position:  4'd0,
    tag_shift:      32'd0,
    chunk_length:   32'd0,
    skip_remaining: 32'd0,
    pad_pending:    1'b0,
    format_seen:    1'b0,
    channels_held:  16'd0,
    rate_held:      32'd0,
    bits_held:      16'd0,
    finished:       1'b0
  };

  // one result word
  typedef struct packed {
    status_e     status;
    logic [15:0] channel_count;
    logic [31:0] samp_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } result_t;

endpackage

/* rtl/whp_byte_if.sv */
// whp_byte_if: input channel of the wav header parser, one file byte per word
// depends on nothing
`timescale 1ns / 1ps

interface whp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output first_byte, output end_of_file,
                  input ready);
  modport sink   (input valid, input file_byte, input first_byte, input end_of_file,
                  output ready);
endinterface

/* rtl/whp_result_if.sv */
// whp_result_if: result channel of the wav header parser, at most one status word per file
// depends on nothing
`timescale 1ns / 1ps

interface whp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channel_count;
  logic [31:0] samp_rate;
  logic [15:0] sample_bits;
  logic [31:0] data_size;

  modport source (output valid, output status, output channel_count, output samp_rate,
                  output sample_bits, output data_size, input ready);
  modport sink   (input valid, input status, input channel_count, input samp_rate,
                  input sample_bits, input data_size, output ready);
endinterface

/* rtl/wav_header_parser.sv */
// wav_header_parser: RIFF/WAVE PCM header parser, top level
// depends on whp_pkg, whp_byte_if, whp_result_if and whp_step
//
// Usage:
//   byte_i carries the file one byte per word, with first_byte marking the
//   start of a new file and end_of_file marking the last byte available.
//   result_o carries at most one status word per file: ok with channels,
//   sample rate, bits per sample and data chunk size, or an error code with
//   all other fields zero. Bytes after the status word are dropped until the
//   next word with first_byte set.
// Timing:
//   one byte is taken every cycle while result_o is not stalled; the parse
//   step for each byte is combinational between the input register and the
//   result register, through which the status word passes to result_o.
// Reset:
//   rst_ni clears the parser to the start-of-file state and empties both
//   registers; a file that begins without first_byte is parsed from its start.
// Stall:
//   while a status word waits on result_o with ready low, the byte in the
//   input register holds and byte_i.ready drops; no word is lost or repeated.
`timescale 1ns / 1ps

module wav_header_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  whp_byte_if.sink            byte_i,
  whp_result_if.source        result_o
);

  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  in_first_q;
  logic                  in_last_q;
  logic                  advance;
  whp_pkg::parse_state_t state_q;
  whp_pkg::parse_state_t state_d;
  logic                  emit;
  whp_pkg::result_t      res;
  whp_pkg::result_t      res_q;
  logic                  out_valid_q;
  logic                  out_valid_d;

  // handshake: process the held byte when the result register can take a word
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign byte_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q  <= byte_i.file_byte;
      in_first_q <= byte_i.first_byte;
      in_last_q  <= byte_i.end_of_file;
    end
  end

  // parse step
  whp_step u_step (
    .state_i       (state_q),
    .file_byte_i   (in_byte_q),
    .first_byte_i  (in_first_q),
    .end_of_file_i (in_last_q),
    .state_o       (state_d),
    .emit_o        (emit),
    .result_o      (res)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whp_pkg::PARSE_CLEAR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_comb begin
    if (advance) begin
      out_valid_d = emit;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = res_q.status;
  assign result_o.channel_count = res_q.channel_count;
  assign result_o.samp_rate     = res_q.samp_rate;
  assign result_o.sample_bits   = res_q.sample_bits;
  assign result_o.data_size     = res_q.data_size;

  // checks
  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != whp_pkg::ST_OK) |->
    (res_q.channel_count == 16'd0 && res_q.samp_rate == 32'd0 &&
     res_q.sample_bits == 16'd0 && res_q.data_size == 32'd0))
    else $error("error status with nonzero fields");

  a_emit_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> state_q.finished)
    else $error("result given without finishing the parse");

  a_quiet_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.finished && !in_first_q) |=> !out_valid_q)
    else $error("second result for one file");

  a_riff_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == whp_pkg::PH_RIFF) |-> (state_q.byte_position <= whp_pkg::POS_RIFF_LAST))
    else $error("riff header position out of range");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !result_o.ready) |-> !byte_i.ready)
    else $error("byte taken while result register is stalled");

endmodule

/* rtl/whp_step.sv */
// whp_step: combinational update of the parser state for one file byte
// depends on whp_pkg
`timescale 1ns / 1ps

module whp_step (
  input  whp_pkg::parse_state_t state_i,
  input  logic [7:0]            file_byte_i,
  input  logic                  first_byte_i,
  input  logic                  end_of_file_i,
  output whp_pkg::parse_state_t state_o,
  output logic                  emit_o,
  output whp_pkg::result_t      result_o
);

  // enter skip of a chunk body, with pad byte on odd chunk length
  function automatic whp_pkg::parse_state_t start_skip(input whp_pkg::parse_state_t s,
                                                       input logic [31:0] len);
    whp_pkg::parse_state_t r;
    r                = s;
    r.pad_pending    = s.chunk_length[0];
    r.skip_remaining = len;
    r.byte_position  = '0;
    r.phase          = (len == 32'd0 && !r.pad_pending) ? whp_pkg::PH_HDR : whp_pkg::PH_SKIP;
    return r;
  endfunction

  whp_pkg::parse_state_t cur;
  whp_pkg::parse_state_t nxt;
  whp_pkg::status_e      code;
  logic                  hit;
  logic                  ignore;
  logic [3:0]            pos;
  logic [31:0]           byte_lane;
  logic [31:0]           shifted;
  logic [31:0]           ts;
  logic [31:0]           len_n;
  logic [31:0]           skip_n;

  // restart on a first byte, ignore bytes after the result
  assign cur       = first_byte_i ? whp_pkg::PARSE_CLEAR : state_i;
  assign ignore    = !first_byte_i && state_i.finished;
  assign pos       = cur.byte_position;
  assign byte_lane = {24'd0, file_byte_i};
  assign shifted   = byte_lane << {pos[1:0], 3'b000};

  // per-phase byte handling
  always_comb begin
    nxt    = cur;
    hit    = 1'b0;
    code   = whp_pkg::ST_OK;
    ts     = {cur.tag_shift[23:0], file_byte_i};
    len_n  = cur.chunk_length | shifted;
    skip_n = cur.skip_remaining;
    unique case (cur.phase)
      whp_pkg::PH_RIFF: begin
        nxt.tag_shift = ts;
        if (pos == whp_pkg::POS_RIFF_TAG_LAST) begin
          nxt.pad_pending = (ts != whp_pkg::TAG_RIFF);
        end
        if (pos >= whp_pkg::POS_RIFF_LAST) begin
          if (nxt.pad_pending || ts != whp_pkg::TAG_WAVE) begin
            hit  = 1'b1;
            code = whp_pkg::ST_NOT_WAVE;
          end else begin
            nxt.pad_pending   = 1'b0;
            nxt.phase         = whp_pkg::PH_HDR;
            nxt.byte_position = '0;
          end
        end else begin
          nxt.byte_position = pos + 4'd1;
        end
      end
      whp_pkg::PH_HDR: begin
        if (pos < whp_pkg::POS_HDR_TAG_END) begin
          nxt.tag_shift = ts;
          if (pos == 4'd0) begin
            nxt.chunk_length = '0;
          end
          nxt.byte_position = pos + 4'd1;
        end else begin
          nxt.chunk_length = len_n;
          if (pos < whp_pkg::POS_HDR_LAST) begin
            nxt.byte_position = pos + 4'd1;
          end else if (cur.tag_shift == whp_pkg::TAG_FMT) begin
            if (len_n < whp_pkg::FMT_BODY_LEN) begin
              hit  = 1'b1;
              code = whp_pkg::ST_FMT_SHORT;
            end else begin
              nxt.phase         = whp_pkg::PH_FMT;
              nxt.byte_position = '0;
              nxt.tag_shift     = '0;
            end
          end else if (cur.tag_shift == whp_pkg::TAG_DATA) begin
            hit  = 1'b1;
            code = cur.format_seen ? whp_pkg::ST_OK : whp_pkg::ST_NO_FMT;
          end else begin
            nxt = start_skip(nxt, len_n);
          end
        end
      end
      whp_pkg::PH_FMT: begin
        // format tag, channels, rate and bits fields of the fmt body
        if (pos < whp_pkg::POS_FMT_TAG_END) begin
          nxt.tag_shift = cur.tag_shift | shifted;
        end else if (pos < whp_pkg::POS_FMT_RATE_LO) begin
          nxt.channels_held = (pos == whp_pkg::POS_FMT_CH_HI) ?
                              {file_byte_i, cur.channels_held[7:0]} : {8'd0, file_byte_i};
        end else if (pos < whp_pkg::POS_FMT_RATE_END) begin
          nxt.rate_held = (pos == whp_pkg::POS_FMT_RATE_LO) ? byte_lane
                                                             : (cur.rate_held | shifted);
        end else if (pos >= whp_pkg::POS_FMT_BITS_LO) begin
          nxt.bits_held = (pos == whp_pkg::POS_FMT_LAST) ?
                          {file_byte_i, cur.bits_held[7:0]} : {8'd0, file_byte_i};
        end
        if (pos < whp_pkg::POS_FMT_LAST) begin
          nxt.byte_position = pos + 4'd1;
        end else if (cur.tag_shift[15:0] != whp_pkg::PCM_TAG) begin
          hit  = 1'b1;
          code = whp_pkg::ST_NOT_PCM;
        end else begin
          nxt.format_seen = 1'b1;
          nxt = start_skip(nxt, cur.chunk_length - whp_pkg::FMT_BODY_LEN);
        end
      end
      whp_pkg::PH_SKIP: begin
        if (cur.skip_remaining != 32'd0) begin
          skip_n = cur.skip_remaining - 32'd1;
        end else begin
          nxt.pad_pending = 1'b0;
        end
        nxt.skip_remaining = skip_n;
        if (skip_n == 32'd0 && !nxt.pad_pending) begin
          nxt.phase         = whp_pkg::PH_HDR;
          nxt.byte_position = '0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    // early end of input
    if (!hit && end_of_file_i) begin
      hit  = 1'b1;
      code = whp_pkg::ST_TRUNCATED;
    end
    if (hit) begin
      nxt.finished = 1'b1;
    end
  end

  // result word and state hand-off
  always_comb begin
    result_o.status = code;
    if (code == whp_pkg::ST_OK) begin
      result_o.channel_count = nxt.channels_held;
      result_o.samp_rate     = nxt.rate_held;
      result_o.sample_bits   = nxt.bits_held;
      result_o.data_size     = len_n;
    end else begin
      result_o.channel_count = '0;
      result_o.samp_rate     = '0;
      result_o.sample_bits   = '0;
      result_o.data_size     = '0;
    end
    state_o = ignore ? state_i : nxt;
    emit_o  = hit && !ignore;
  end

endmodule

/* bench/tb_wav_header_parser.sv */
// tb_wav_header_parser: self-checking bench for the riff/wave pcm header parser
// feeds whole files byte by byte and checks each status word against a local parser model
// depends on whp_pkg, whp_byte_if, whp_result_if and wav_header_parser
`timescale 1ns / 1ps

module tb_wav_header_parser;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned BYTE_TARGET  = 1250;
  localparam int unsigned MIN_FILES    = 10;
  localparam int unsigned PRINT_CAP    = 20;

  // tags of chunks the parser only skips
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_JUNK = 32'h4A55_4E4B;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
    logic       end_of_file;
  } byte_word_t;

  logic clk_i;
  logic rst_ni;

  whp_byte_if   byte_if ();
  whp_result_if res_if ();

  wav_header_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if)
  );

  byte_word_t        send_q[$];
  whp_pkg::result_t  status_q[$];
  logic [7:0]        file_buf[$];

  int unsigned bytes_taken;
  int unsigned total_bytes;
  int unsigned words_checked;
  int unsigned ok_words;
  int unsigned mismatches;

  // local copy of the parser state
  whp_pkg::phase_e walk_phase;
  logic [4:0]      walk_pos;
  logic [31:0]     tag_window;
  logic [31:0]     size_acc;
  logic [31:0]     skip_left;
  logic            pad_due;
  logic            fmt_taken;
  logic [15:0]     hold_chan;
  logic [31:0]     hold_rate;
  logic [15:0]     hold_bits;
  logic            file_done;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic parser_clear();
    walk_phase = whp_pkg::PH_RIFF;
    walk_pos   = '0;
    tag_window = '0;
    size_acc   = '0;
    skip_left  = '0;
    pad_due    = 1'b0;
    fmt_taken  = 1'b0;
    hold_chan  = '0;
    hold_rate  = '0;
    hold_bits  = '0;
    file_done  = 1'b0;
  endtask

  // close the file with one status word; fields only carry values when ok
  task automatic finish_file(input whp_pkg::status_e st, input logic [31:0] size,
                             output whp_pkg::result_t r);
    file_done = 1'b1;
    r = '0;
    r.status = st;
    if (st == whp_pkg::ST_OK) begin
      r.channel_count = hold_chan;
      r.samp_rate     = hold_rate;
      r.sample_bits   = hold_bits;
      r.data_size     = size;
    end
  endtask

  task automatic begin_skip(input logic [31:0] len);
    pad_due    = size_acc[0];
    skip_left  = len;
    walk_pos   = '0;
    walk_phase = (len == 32'd0 && !pad_due) ? whp_pkg::PH_HDR : whp_pkg::PH_SKIP;
  endtask

  // advance the parser by one byte; hit tells whether a status word follows
  task automatic parse_byte(input logic [7:0] b, input logic first, input logic last,
                            output logic hit, output whp_pkg::result_t r);
    logic [1:0] lane;
    hit = 1'b0;
    r = '0;
    if (first) begin
      parser_clear();
    end else if (file_done) begin
      return;
    end
    unique case (walk_phase)
      whp_pkg::PH_RIFF: begin
        tag_window = {tag_window[23:0], b};
        if (walk_pos == 5'd3) pad_due = (tag_window != whp_pkg::TAG_RIFF);
        if (walk_pos >= 5'd11) begin
          if (pad_due || tag_window != whp_pkg::TAG_WAVE) begin
            finish_file(whp_pkg::ST_NOT_WAVE, '0, r);
            hit = 1'b1;
          end else begin
            pad_due    = 1'b0;
            walk_phase = whp_pkg::PH_HDR;
            walk_pos   = '0;
          end
        end else begin
          walk_pos = walk_pos + 5'd1;
        end
      end
      whp_pkg::PH_HDR: begin
        if (walk_pos < 5'd4) begin
          tag_window = {tag_window[23:0], b};
          if (walk_pos == 5'd0) size_acc = '0;
          walk_pos = walk_pos + 5'd1;
        end else begin
          lane = walk_pos[1:0];
          size_acc[8 * lane +: 8] = b;
          if (walk_pos < 5'd7) begin
            walk_pos = walk_pos + 5'd1;
          end else if (tag_window == whp_pkg::TAG_FMT) begin
            if (size_acc < whp_pkg::FMT_BODY_LEN) begin
              finish_file(whp_pkg::ST_FMT_SHORT, '0, r);
              hit = 1'b1;
            end else begin
              walk_phase = whp_pkg::PH_FMT;
              walk_pos   = '0;
              tag_window = '0;
            end
          end else if (tag_window == whp_pkg::TAG_DATA) begin
            finish_file(fmt_taken ? whp_pkg::ST_OK : whp_pkg::ST_NO_FMT, size_acc, r);
            hit = 1'b1;
          end else begin
            begin_skip(size_acc);
          end
        end
      end
      whp_pkg::PH_FMT: begin
        // format tag, channels, rate, then bits in the last two bytes
        if (walk_pos < 5'd2) begin
          tag_window[8 * walk_pos +: 8] = b;
        end else if (walk_pos == 5'd2) begin
          hold_chan = {8'h00, b};
        end else if (walk_pos == 5'd3) begin
          hold_chan[15:8] = b;
        end else if (walk_pos == 5'd4) begin
          hold_rate = {24'h0, b};
        end else if (walk_pos < 5'd8) begin
          lane = walk_pos[1:0];
          hold_rate[8 * lane +: 8] = b;
        end else if (walk_pos == 5'd14) begin
          hold_bits = {8'h00, b};
        end else if (walk_pos == 5'd15) begin
          hold_bits[15:8] = b;
        end
        if (walk_pos < 5'd15) begin
          walk_pos = walk_pos + 5'd1;
        end else if (tag_window[15:0] != whp_pkg::PCM_TAG) begin
          finish_file(whp_pkg::ST_NOT_PCM, '0, r);
          hit = 1'b1;
        end else begin
          fmt_taken = 1'b1;
          begin_skip(size_acc - whp_pkg::FMT_BODY_LEN);
        end
      end
      default: begin
        if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
        else pad_due = 1'b0;
        if (skip_left == 32'd0 && !pad_due) begin
          walk_phase = whp_pkg::PH_HDR;
          walk_pos   = '0;
        end
      end
    endcase
    if (!hit && last) begin
      finish_file(whp_pkg::ST_TRUNCATED, '0, r);
      hit = 1'b1;
    end
  endtask

  // file building

  function automatic logic [31:0] wide32();
    unique case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] odd_tag();
    unique case ($urandom_range(0, 5))
      0: return whp_pkg::TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
      1: return whp_pkg::TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
      2: return whp_pkg::TAG_WAVE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] big_size();
    return $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
  endfunction

  task automatic put_tag(input logic [31:0] t);
    file_buf.push_back(t[31:24]);
    file_buf.push_back(t[23:16]);
    file_buf.push_back(t[15:8]);
    file_buf.push_back(t[7:0]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    file_buf.push_back(v[7:0]);
    file_buf.push_back(v[15:8]);
    file_buf.push_back(v[23:16]);
    file_buf.push_back(v[31:24]);
  endtask

  task automatic put_le16(input logic [15:0] v);
    file_buf.push_back(v[7:0]);
    file_buf.push_back(v[15:8]);
  endtask

  task automatic put_fill(input int unsigned n);
    repeat (n) file_buf.push_back(8'($urandom));
  endtask

  task automatic put_riff(input logic [31:0] riff, input logic [31:0] wave);
    put_tag(riff);
    put_le32($urandom);
    put_tag(wave);
  endtask

  // fmt chunk; a long one only gets a few body bytes and must be cut short
  task automatic put_fmt(input logic [31:0] len, input logic [15:0] code,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] bits);
    put_tag(whp_pkg::TAG_FMT);
    put_le32(len);
    if (len >= whp_pkg::FMT_BODY_LEN) begin
      put_le16(code);
      put_le16(chans);
      put_le32(rate);
      put_le32($urandom);
      put_le16(16'($urandom));
      put_le16(bits);
      if (len - whp_pkg::FMT_BODY_LEN <= 32'd8) begin
        put_fill(len - whp_pkg::FMT_BODY_LEN);
        if (len[0]) put_fill(1);
      end else begin
        put_fill(3);
      end
    end
  endtask

  task automatic put_chunk(input logic [31:0] t, input logic [31:0] len);
    put_tag(t);
    put_le32(len);
    if (len <= 32'd16) begin
      put_fill(len);
      if (len[0]) put_fill(1);
    end else begin
      put_fill(4);
    end
  endtask

  task automatic put_data(input logic [31:0] size);
    put_tag(whp_pkg::TAG_DATA);
    put_le32(size);
  endtask

  task automatic cut_file(input int unsigned n);
    while (file_buf.size() > n) void'(file_buf.pop_back());
  endtask

  // move the built file into the send queue with its start and end flags
  task automatic ship_file(input bit first, input bit eof);
    byte_word_t w;
    foreach (file_buf[i]) begin
      w.file_byte   = file_buf[i];
      w.first_byte  = first && (i == 0);
      w.end_of_file = eof && (i == file_buf.size() - 1);
      send_q.push_back(w);
    end
    file_buf.delete();
  endtask

  // mostly well-formed files with random content, the rest broken or noise
  task automatic make_random_file();
    int unsigned kind;
    int unsigned ending;
    int unsigned k;
    bit          force_eof;
    kind = $urandom_range(0, 99);
    force_eof = 1'b0;
    if (kind < 60) begin
      put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
      repeat ($urandom_range(0, 2)) put_chunk(odd_tag(), $urandom_range(0, 7));
      put_fmt($urandom_range(16, 21), whp_pkg::PCM_TAG, 16'(wide32()), wide32(),
              16'(wide32()));
      if ($urandom_range(0, 9) == 0)
        put_fmt(whp_pkg::FMT_BODY_LEN, whp_pkg::PCM_TAG, 16'(wide32()), wide32(),
                16'(wide32()));
      repeat ($urandom_range(0, 1)) put_chunk(odd_tag(), $urandom_range(0, 7));
      put_data(wide32());
    end else if (kind < 68) begin
      k = $urandom_range(0, 31);
      if ($urandom_range(0, 1)) put_riff(whp_pkg::TAG_RIFF ^ (32'd1 << k), whp_pkg::TAG_WAVE);
      else put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE ^ (32'd1 << k));
    end else if (kind < 74) begin
      put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
      put_fmt($urandom_range(0, 15), whp_pkg::PCM_TAG, '0, '0, '0);
    end else if (kind < 80) begin
      put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
      put_fmt($urandom_range(16, 19),
              $urandom_range(0, 1) ? whp_pkg::PCM_TAG ^ (16'd1 << $urandom_range(0, 15))
                                   : 16'($urandom),
              16'(wide32()), wide32(), 16'(wide32()));
      put_data(wide32());
    end else if (kind < 86) begin
      put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
      repeat ($urandom_range(0, 1)) put_chunk(odd_tag(), $urandom_range(0, 7));
      put_data(wide32());
    end else if (kind < 94) begin
      // huge chunk sizes, always cut off by end of input
      put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
      if ($urandom_range(0, 1))
        put_fmt(whp_pkg::FMT_BODY_LEN, whp_pkg::PCM_TAG, 16'(wide32()), wide32(), '0);
      if ($urandom_range(0, 1)) put_chunk(odd_tag(), big_size());
      else put_fmt(big_size(), whp_pkg::PCM_TAG, 16'(wide32()), wide32(), 16'(wide32()));
      force_eof = 1'b1;
    end else begin
      put_fill($urandom_range(1, 20));
    end
    ending = $urandom_range(0, 99);
    if (ending < 15) begin
      cut_file($urandom_range(1, file_buf.size()));
      force_eof = 1'b1;
    end else if (ending < 20) begin
      cut_file($urandom_range(1, file_buf.size()));
    end else if (ending < 35) begin
      force_eof = 1'b1;
    end
    ship_file($urandom_range(0, 19) != 0, force_eof);
    // stray bytes after the end, normally ignored
    if ($urandom_range(0, 9) == 0) begin
      put_fill($urandom_range(1, 4));
      ship_file(1'b0, $urandom_range(0, 1));
    end
  endtask

  // idle lengths: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int unsigned next_calm(input int unsigned calm);
    if (calm != 0) return calm - 1;
    return ($urandom_range(0, 99) == 0) ? $urandom_range(30, 120) : 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic check_word();
    whp_pkg::result_t want;
    if (status_q.size() == 0) begin
      report_mismatch("status word with none pending, status", 32'(res_if.status), '0);
      return;
    end
    want = status_q.pop_front();
    words_checked++;
    if (want.status == whp_pkg::ST_OK) ok_words++;
    if (res_if.status != want.status)
      report_mismatch("status", 32'(res_if.status), 32'(want.status));
    if (res_if.channel_count != want.channel_count)
      report_mismatch("channel_count", 32'(res_if.channel_count), 32'(want.channel_count));
    if (res_if.samp_rate != want.samp_rate)
      report_mismatch("samp_rate", res_if.samp_rate, want.samp_rate);
    if (res_if.sample_bits != want.sample_bits)
      report_mismatch("sample_bits", 32'(res_if.sample_bits), 32'(want.sample_bits));
    if (res_if.data_size != want.data_size)
      report_mismatch("data_size", res_if.data_size, want.data_size);
  endtask

  // byte driver: one word from the send queue whenever the channel is free and no idle gap is pending
  int unsigned send_gap;
  int unsigned send_calm;

  always @(posedge clk_i or negedge rst_ni) begin : drive_bytes
    byte_word_t next_word;
    if (!rst_ni) begin
      byte_if.valid       <= 1'b0;
      byte_if.file_byte   <= '0;
      byte_if.first_byte  <= 1'b0;
      byte_if.end_of_file <= 1'b0;
      send_gap            <= 0;
      send_calm           <= 0;
    end else if (!byte_if.valid || byte_if.ready) begin
      if (send_gap != 0) begin
        byte_if.valid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (send_q.size() != 0) begin
        next_word = send_q.pop_front();
        byte_if.valid       <= 1'b1;
        byte_if.file_byte   <= next_word.file_byte;
        byte_if.first_byte  <= next_word.first_byte;
        byte_if.end_of_file <= next_word.end_of_file;
        send_gap            <= (send_calm != 0) ? 0 : pick_gap();
        send_calm           <= next_calm(send_calm);
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // byte monitor: every accepted byte steps the local parser
  always @(posedge clk_i) begin : watch_bytes
    logic             hit;
    whp_pkg::result_t r;
    if (!rst_ni) begin
      parser_clear();
    end else if (byte_if.valid && byte_if.ready) begin
      parse_byte(byte_if.file_byte, byte_if.first_byte, byte_if.end_of_file, hit, r);
      bytes_taken++;
      if (hit) status_q.push_back(r);
    end
  end

  // result monitor: random back-pressure and compare against the oldest status
  int unsigned take_gap;
  int unsigned take_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      take_gap     <= 0;
      take_calm    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) check_word();
      if (take_gap != 0) begin
        res_if.ready <= 1'b0;
        take_gap     <= take_gap - 1;
      end else begin
        res_if.ready <= 1'b1;
        take_gap     <= (take_calm != 0) ? 0 : pick_gap();
        take_calm    <= next_calm(take_calm);
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d idle cycles", IDLE_LIMIT);
    $display("wav_header_parser: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_files;
    rst_ni = 1'b0;

    // first file right after reset with no start flag, all fields at their maximum
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    put_fmt(whp_pkg::FMT_BODY_LEN, whp_pkg::PCM_TAG, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put_data(32'hFFFF_FFFF);
    ship_file(1'b0, 1'b0);
    // skipped chunks with pad bytes, long fmt, zero fields, end flag on the deciding byte
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    put_chunk(TAG_LIST, 32'd3);
    put_chunk(TAG_JUNK, 32'd0);
    put_fmt(32'd19, whp_pkg::PCM_TAG, '0, '0, '0);
    put_data('0);
    ship_file(1'b1, 1'b1);
    // bytes after the status word, end flag included
    put_fill(3);
    ship_file(1'b0, 1'b1);
    // bad riff tag, bad wave tag
    put_riff(whp_pkg::TAG_RIFF ^ 32'd1, whp_pkg::TAG_WAVE);
    ship_file(1'b1, 1'b0);
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE ^ 32'h8000_0000);
    ship_file(1'b1, 1'b0);
    // bad riff tag but the header never completes
    put_riff(whp_pkg::TAG_RIFF ^ 32'h100, whp_pkg::TAG_WAVE);
    cut_file(5);
    ship_file(1'b1, 1'b1);
    // fmt too short, not pcm, data with no fmt
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    put_fmt(32'd15, whp_pkg::PCM_TAG, '0, '0, '0);
    ship_file(1'b1, 1'b0);
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    put_fmt(whp_pkg::FMT_BODY_LEN, 16'd3, 16'd2, 32'd48000, 16'd24);
    ship_file(1'b1, 1'b0);
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    put_chunk(TAG_LIST, 32'd1);
    put_data(32'd100);
    ship_file(1'b1, 1'b0);
    // end of input exactly at a chunk boundary
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    ship_file(1'b1, 1'b1);
    // second fmt chunk replaces the first
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    put_fmt(whp_pkg::FMT_BODY_LEN, whp_pkg::PCM_TAG, 16'd1, 32'd8000, 16'd8);
    put_fmt(32'd17, whp_pkg::PCM_TAG, 16'd2, 32'd44100, 16'd16);
    put_data(32'd1024);
    ship_file(1'b1, 1'b0);
    // file abandoned inside fmt, then a one-byte file
    put_riff(whp_pkg::TAG_RIFF, whp_pkg::TAG_WAVE);
    put_fmt(whp_pkg::FMT_BODY_LEN, whp_pkg::PCM_TAG, 16'd1, 32'd22050, 16'd16);
    cut_file(25);
    ship_file(1'b1, 1'b0);
    file_buf.push_back(8'hFF);
    ship_file(1'b1, 1'b1);

    random_files = 0;
    while (send_q.size() < BYTE_TARGET || random_files < MIN_FILES) begin
      make_random_file();
      random_files++;
    end
    total_bytes = send_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != total_bytes) @(posedge clk_i);
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d bytes over %0d random files plus directed cases",
             total_bytes, random_files);
    $display("compared %0d status words, %0d ok and %0d error codes",
             words_checked, ok_words, words_checked - ok_words);
    if (mismatches == 0) begin
      $display("wav_header_parser: match");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("wav_header_parser: mismatch");
    end
    $finish;
  end

endmodule
